// ===== hw/rtl/stsu_pkg.sv =====
// Shared types, widths, constants and the quarter-wave sine table for the secant unit.
package stsu_pkg;

   localparam int STEP_W     = 8;
   localparam int ANGLE_W    = 8;
   localparam int SCALE_W    = 16;
   localparam int RES_W      = 16;
   localparam int MAG_W      = 31;
   localparam int REM_W      = 31;
   localparam int QUOT_W     = 30;
   localparam int PROD_W     = SCALE_W + MAG_W;
   localparam int FRAC_BITS  = 30;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUOT_W / DIV_BITS_PER_STAGE;
   localparam int TAB_IDX_W  = 7;

   localparam int STEP_BITS_DEFAULT = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SCALE = 1'b0;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   localparam logic [RES_W-1:0] CLAMP_TOP = 16'h3fff;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] STEP_Q30 = 64'd26353589;

   typedef logic [64:0][MAG_W-1:0] sine_tab_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] quot;
      logic [MAG_W-1:0]  div;
      logic              zero;
      logic              neg;
   } lane_type;

   typedef struct packed {
      lane_type         cos_lane;
      lane_type         sin_lane;
      logic [RES_W-1:0] times_cos;
      logic [RES_W-1:0] times_sin;
   } pipe_type;

   // Polynomial sine of r*pi/128 in Q30, evaluated only at elaboration.
   function automatic logic [MAG_W-1:0] quarter_sine(logic [TAB_IDX_W-1:0] r);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] full;
      u  = 64'(r) * STEP_Q30;
      u2 = (u * u) >> FRAC_BITS;
      t  = Q30_ONE;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd272;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd210;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd156;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd110;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd72;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd42;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd20;
      t  = Q30_ONE - ((u2 * t) >> FRAC_BITS) / 64'd6;
      full = (u * t) >> FRAC_BITS;
      return full[MAG_W-1:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int r = 0; r <= 64; r++) begin
         tab[r] = quarter_sine(TAB_IDX_W'(r));
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   // Magnitude of the sine of an angle index, folded into the first quadrant.
   function automatic logic [MAG_W-1:0] sine_mag(logic [ANGLE_W-1:0] angle);
      logic [TAB_IDX_W-1:0] idx;
      if (angle[6]) begin
         idx = TAB_IDX_W'(64) - {1'b0, angle[5:0]};
      end else begin
         idx = {1'b0, angle[5:0]};
      end
      return SINE_TAB[idx];
   endfunction

   // One restoring division step: shift in a zero numerator bit, subtract when it fits.
   function automatic lane_type div_step(lane_type lane);
      lane_type   res;
      logic [REM_W:0] r2;
      res = lane;
      r2  = {lane.rem, 1'b0};
      if (r2 >= {1'b0, lane.div}) begin
         res.rem  = REM_W'(r2 - {1'b0, lane.div});
         res.quot = {lane.quot[QUOT_W-2:0], 1'b1};
      end else begin
         res.rem  = r2[REM_W-1:0];
         res.quot = {lane.quot[QUOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/stsu_req_if.sv =====
// Input channel: distance step and angle index with a valid/ready handshake.
interface stsu_req_if;
   import stsu_pkg::*;
   logic               valid;
   logic               ready;
   logic [STEP_W-1:0]  step;
   logic [ANGLE_W-1:0] angle;
   modport source (output valid, output step, output angle, input ready);
   modport sink (input valid, input step, input angle, output ready);
endinterface

// ===== hw/rtl/stsu_rsp_if.sv =====
// Result channel: the four scaled trigonometric values with a valid/ready handshake.
interface stsu_rsp_if;
   import stsu_pkg::*;
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] over_cos;
   logic [RES_W-1:0] over_sin;
   logic [RES_W-1:0] times_cos;
   logic [RES_W-1:0] times_sin;
   modport source (output valid, output over_cos, output over_sin,
                   output times_cos, output times_sin, input ready);
   modport sink (input valid, input over_cos, input over_sin,
                 input times_cos, input times_sin, output ready);
endinterface

// ===== hw/rtl/scaled_trig_secant_unit.sv =====
// Throughput: one transaction per cycle; the whole pipeline holds while a response stalls.
// Stages: input register, table lookup, products, fifteen divider stages, output register.
// The divider makes two quotient bits per stage per lane, which sets the depth.
// Reset clears every stage's valid bit and loads the scale register with 256.
module scaled_trig_secant_unit #(
   parameter int STEP_BITS = stsu_pkg::STEP_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   stsu_req_if.sink                         req,
   stsu_rsp_if.source                       rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [stsu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [stsu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [stsu_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import stsu_pkg::*;

   logic               adv;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_sel;

   logic               stage_valid [DIV_STAGES+1];
   pipe_type           stage_pipe  [DIV_STAGES+1];

   logic               out_valid_ff;
   logic [RES_W-1:0]   over_cos_ff;
   logic [RES_W-1:0]   over_sin_ff;
   logic [RES_W-1:0]   times_cos_ff;
   logic [RES_W-1:0]   times_sin_ff;
   logic [RES_W-1:0]   over_cos_in;
   logic [RES_W-1:0]   over_sin_in;

   // Configuration register.
   assign csr_sel    = (csr_paddr[2] == REG_SCALE);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_sel ? CSR_DATA_W'(scale_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel) begin
         scale_ff <= csr_pwdata[SCALE_W-1:0];
      end
   end

   // The pipeline moves whenever the output register is free or being emptied.
   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   stsu_front #(
      .STEP_BITS (STEP_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req.valid),
      .in_step   (req.step),
      .in_angle  (req.angle),
      .scale     (scale_ff),
      .out_valid (stage_valid[0]),
      .out_pipe  (stage_pipe[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      stsu_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (stage_valid[g]),
         .in_pipe   (stage_pipe[g]),
         .out_valid (stage_valid[g+1]),
         .out_pipe  (stage_pipe[g+1])
      );
   end

   function automatic logic [RES_W-1:0] finish(lane_type lane);
      logic [RES_W-1:0] res;
      if (lane.zero) begin
         res = CLAMP_TOP;
      end else if (lane.neg) begin
         res = RES_W'(0) - lane.quot[RES_W-1:0];
      end else if (lane.quot > QUOT_W'(CLAMP_TOP)) begin
         res = CLAMP_TOP;
      end else begin
         res = lane.quot[RES_W-1:0];
      end
      return res;
   endfunction

   assign over_cos_in = finish(stage_pipe[DIV_STAGES].cos_lane);
   assign over_sin_in = finish(stage_pipe[DIV_STAGES].sin_lane);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= stage_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         over_cos_ff  <= over_cos_in;
         over_sin_ff  <= over_sin_in;
         times_cos_ff <= stage_pipe[DIV_STAGES].times_cos;
         times_sin_ff <= stage_pipe[DIV_STAGES].times_sin;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.over_cos  = over_cos_ff;
   assign rsp.over_sin  = over_sin_ff;
   assign rsp.times_cos = times_cos_ff;
   assign rsp.times_sin = times_sin_ff;

endmodule

// ===== hw/rtl/stsu_front.sv =====
// Front stages: input register, sine table lookup, scale products and divider setup.
module stsu_front #(
   parameter int STEP_BITS = stsu_pkg::STEP_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [stsu_pkg::STEP_W-1:0]   in_step,
   input  logic [stsu_pkg::ANGLE_W-1:0]  in_angle,
   input  logic [stsu_pkg::SCALE_W-1:0]  scale,
   output logic                          out_valid,
   output stsu_pkg::pipe_type            out_pipe
);
   import stsu_pkg::*;

   localparam int MX_W = SCALE_W + STEP_BITS;

   logic                 a_valid_ff;
   logic [STEP_BITS-1:0] a_step_ff;
   logic [ANGLE_W-1:0]   a_angle_ff;

   logic                 b_valid_ff;
   logic [MX_W-1:0]      b_mx_ff;
   logic [MX_W-1:0]      b_mx_in;
   logic [MAG_W-1:0]     b_cmag_ff;
   logic [MAG_W-1:0]     b_smag_ff;
   logic                 b_cneg_ff;
   logic                 b_sneg_ff;
   logic [ANGLE_W-1:0]   cos_angle;

   logic                 c_valid_ff;
   pipe_type             c_pipe_ff;
   pipe_type             c_pipe_in;
   logic [PROD_W-1:0]    prod_cos;
   logic [PROD_W-1:0]    prod_sin;

   assign cos_angle = a_angle_ff + ANGLE_W'(64);
   assign b_mx_in   = MX_W'(scale) * MX_W'(a_step_ff);

   always_comb begin
      prod_cos = PROD_W'(scale) * PROD_W'(b_cmag_ff);
      prod_sin = PROD_W'(scale) * PROD_W'(b_smag_ff);
      c_pipe_in.cos_lane.rem  = REM_W'(b_mx_ff);
      c_pipe_in.cos_lane.quot = '0;
      c_pipe_in.cos_lane.div  = b_cmag_ff;
      c_pipe_in.cos_lane.zero = (b_cmag_ff == '0);
      c_pipe_in.cos_lane.neg  = b_cneg_ff;
      c_pipe_in.sin_lane.rem  = REM_W'(b_mx_ff);
      c_pipe_in.sin_lane.quot = '0;
      c_pipe_in.sin_lane.div  = b_smag_ff;
      c_pipe_in.sin_lane.zero = (b_smag_ff == '0);
      c_pipe_in.sin_lane.neg  = b_sneg_ff;
      // Truncation toward zero: shift the magnitude, then apply the sign.
      if (b_cneg_ff) begin
         c_pipe_in.times_cos = RES_W'(0) - prod_cos[FRAC_BITS +: RES_W];
      end else begin
         c_pipe_in.times_cos = prod_cos[FRAC_BITS +: RES_W];
      end
      if (b_sneg_ff) begin
         c_pipe_in.times_sin = RES_W'(0) - prod_sin[FRAC_BITS +: RES_W];
      end else begin
         c_pipe_in.times_sin = prod_sin[FRAC_BITS +: RES_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_step_ff  <= in_step[STEP_BITS-1:0];
         a_angle_ff <= in_angle;
         b_mx_ff    <= b_mx_in;
         b_smag_ff  <= sine_mag(a_angle_ff);
         b_sneg_ff  <= a_angle_ff[7];
         b_cmag_ff  <= sine_mag(cos_angle);
         b_cneg_ff  <= cos_angle[7];
         c_pipe_ff  <= c_pipe_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_pipe  = c_pipe_ff;

endmodule

// ===== hw/rtl/stsu_div_stage.sv =====
// One divider stage: two restoring quotient bits for both the cosine and sine lanes.
module stsu_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  stsu_pkg::pipe_type in_pipe,
   output logic               out_valid,
   output stsu_pkg::pipe_type out_pipe
);
   import stsu_pkg::*;

   logic     valid_ff;
   pipe_type pipe_ff;
   pipe_type pipe_in;

   always_comb begin
      pipe_in = in_pipe;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         pipe_in.cos_lane = div_step(pipe_in.cos_lane);
         pipe_in.sin_lane = div_step(pipe_in.sin_lane);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== hw/rtl/stsu_check.sv =====
// Port-level checks on the secant unit, attached to the top level by a bind.
module stsu_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [stsu_pkg::RES_W-1:0]     rsp_over_cos,
   input logic [stsu_pkg::RES_W-1:0]     rsp_over_sin,
   input logic                           csr_pready
);
   import stsu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_over_cos) && $stable(rsp_over_sin))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output register state");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("configuration port not ready");

endmodule

bind scaled_trig_secant_unit stsu_check u_stsu_check (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_over_cos (rsp.over_cos),
   .rsp_over_sin (rsp.over_sin),
   .csr_pready   (csr_pready)
);

// ===== dv/tb.sv =====
// Testbench for the scaled secant and sine unit: table-driven directed rows, then random traffic.
`timescale 1ns / 1ps
module tb;
   import stsu_pkg::*;

   typedef struct packed {
      logic [RES_W-1:0] over_cos;
      logic [RES_W-1:0] over_sin;
      logic [RES_W-1:0] times_cos;
      logic [RES_W-1:0] times_sin;
   } trig_result_t;

   typedef struct {
      logic [STEP_W-1:0]  step;
      logic [ANGLE_W-1:0] angle;
      logic               typed;
      trig_result_t       want;
   } trig_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   stsu_req_if req_if ();
   stsu_rsp_if rsp_if ();

   scaled_trig_secant_unit u_top (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   trig_result_t pending_results[$];
   logic [SCALE_W-1:0] model_scale = SCALE_RESET;
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   function automatic logic [63:0] q30_sine(int unsigned r);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      u = 64'(r) * 64'd26353589;
      u2 = (u * u) >> 30;
      t = 64'd1 << 30;
      for (int n = 8; n >= 1; n--) begin
         t = (64'd1 << 30) - ((u2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
      end
      return (u * t) >> 30;
   endfunction

   function automatic logic [63:0] sine_magnitude(logic [7:0] a, output logic neg);
      neg = a[7];
      return a[6] ? q30_sine(64 - a[5:0]) : q30_sine(a[5:0]);
   endfunction

   function automatic logic [15:0] scaled_by(logic [63:0] m, logic [63:0] mag, logic neg);
      logic [63:0] v;
      v = (m * mag) >> 30;
      return neg ? 16'(-v) : v[15:0];
   endfunction

   function automatic logic [15:0] divided_by(logic [63:0] mx, logic [63:0] mag, logic neg);
      logic [63:0] q;
      if (mag == 0) return CLAMP_TOP;
      q = (mx << 30) / mag;
      if (neg) return 16'(-q);
      return (q > 64'h3fff) ? CLAMP_TOP : q[15:0];
   endfunction

   function automatic trig_result_t predict_trig(logic [7:0] step, logic [7:0] angle);
      trig_result_t res;
      logic sneg, cneg;
      logic [63:0] smag, cmag, mx;
      mx = 64'(model_scale) * 64'(step);
      smag = sine_magnitude(angle, sneg);
      cmag = sine_magnitude(angle + 8'd64, cneg);
      res.over_cos = (angle == 8'd64 || angle == 8'd192) ? CLAMP_TOP
                     : divided_by(mx, cmag, cneg);
      res.over_sin = (angle == 8'd0 || angle == 8'd128) ? CLAMP_TOP
                     : divided_by(mx, smag, sneg);
      res.times_cos = scaled_by(64'(model_scale), cmag, cneg);
      res.times_sin = scaled_by(64'(model_scale), smag, sneg);
      return res;
   endfunction

   // Receiver side: random stall and in-order comparison.
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      trig_result_t got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.over_cos, rsp_if.over_sin, rsp_if.times_cos, rsp_if.times_sin};
         if (pending_results.size() == 0) begin
            $error("unexpected transaction %h", got);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.over_cos !== want.over_cos) begin
               $error("over_cos expected %h actual %h", want.over_cos, got.over_cos);
               fail_count++;
            end
            if (got.over_sin !== want.over_sin) begin
               $error("over_sin expected %h actual %h", want.over_sin, got.over_sin);
               fail_count++;
            end
            if (got.times_cos !== want.times_cos) begin
               $error("times_cos expected %h actual %h", want.times_cos, got.times_cos);
               fail_count++;
            end
            if (got.times_sin !== want.times_sin) begin
               $error("times_sin expected %h actual %h", want.times_sin, got.times_sin);
               fail_count++;
            end
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_scale(logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(REG_SCALE) << 2;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_scale = value;
   endtask

   // Holds valid until the transaction is taken; before raising it, inserts random idle gaps at the send_idle_pct rate.
   task automatic send_item(logic [7:0] step, logic [7:0] angle, trig_result_t want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.step <= step;
      req_if.angle <= angle;
      pending_results.push_back(want);
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic random_items(int count);
      logic [7:0] s, a;
      for (int i = 0; i < count; i++) begin
         s = 8'($urandom());
         case ($urandom_range(5))
            0: a = 8'($urandom_range(3)) << 6;
            1: a = (8'($urandom_range(3)) << 6) + 8'($urandom_range(2)) - 8'd1;
            default: a = 8'($urandom());
         endcase
         send_item(s, a, predict_trig(s, a));
      end
      req_if.valid <= 1'b0;
   endtask

   trig_row_t directed_rows[] = '{
      '{8'd0,   8'd0,   1'b1, '{16'h0000, 16'h3fff, 16'd256, 16'd0}},
      '{8'd255, 8'd0,   1'b1, '{16'h3fff, 16'h3fff, 16'd256, 16'd0}},
      '{8'd1,   8'd0,   1'b0, '{default: '0}},
      '{8'd0,   8'd64,  1'b0, '{default: '0}},
      '{8'd255, 8'd64,  1'b0, '{default: '0}},
      '{8'd7,   8'd128, 1'b0, '{default: '0}},
      '{8'd7,   8'd192, 1'b0, '{default: '0}},
      '{8'd1,   8'd32,  1'b0, '{default: '0}},
      '{8'd200, 8'd96,  1'b0, '{default: '0}},
      '{8'd3,   8'd160, 1'b0, '{default: '0}},
      '{8'd3,   8'd224, 1'b0, '{default: '0}},
      '{8'd255, 8'd255, 1'b0, '{default: '0}},
      '{8'd170, 8'd85,  1'b0, '{default: '0}},
      '{8'd85,  8'd170, 1'b0, '{default: '0}},
      '{8'd1,   8'd1,   1'b0, '{default: '0}},
      '{8'd1,   8'd63,  1'b0, '{default: '0}},
      '{8'd1,   8'd127, 1'b0, '{default: '0}}
   };

   initial begin
      req_if.valid = 1'b0;
      req_if.step = '0;
      req_if.angle = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].step, directed_rows[i].angle,
                   directed_rows[i].typed ? directed_rows[i].want
                   : predict_trig(directed_rows[i].step, directed_rows[i].angle));
      end
      req_if.valid <= 1'b0;
      drain();
      // Extreme scales first, then ordinary ones, across the three idle profiles.
      write_scale(16'hffff);
      send_idle_pct = 19; recv_idle_pct = 78;
      random_items(300);
      drain();
      write_scale(16'd0);
      random_items(150);
      drain();
      write_scale(16'd1);
      send_idle_pct = 78; recv_idle_pct = 19;
      random_items(300);
      drain();
      write_scale(16'($urandom()));
      random_items(300);
      drain();
      write_scale(16'h5aa5);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_items(400);
      drain();
      write_scale(16'h8000);
      random_items(400);
      drain();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/stsu_pkg.sv
hw/rtl/stsu_req_if.sv
hw/rtl/stsu_rsp_if.sv
hw/rtl/stsu_front.sv
hw/rtl/stsu_div_stage.sv
hw/rtl/scaled_trig_secant_unit.sv
hw/rtl/stsu_check.sv
dv/tb.sv
